// ===== src/char_lcd_number_writer_core_macros.svh =====
// ----------------------------------------------------------------------------
// char_lcd_number_writer_core_macros.svh
// Assertion shorthands shared by the LCD number writer modules.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NUMBER_WRITER_CORE_MACROS_SVH
`define CHAR_LCD_NUMBER_WRITER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LCDNW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LCDNW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lcdnw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Types, constants and the control store of the LCD number writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnw_pkg;

  // Request action codes
  localparam logic [2:0] ACT_CHAR = 3'd0;
  localparam logic [2:0] ACT_UDEC = 3'd1;
  localparam logic [2:0] ACT_SDEC = 3'd2;
  localparam logic [2:0] ACT_HEX  = 3'd3;
  localparam logic [2:0] ACT_BIN  = 3'd4;

  // Digit limits and conversion length
  localparam int unsigned MaxDigits = 16;
  localparam int unsigned CntW      = 5;
  localparam int unsigned PosW      = 4;
  localparam int unsigned ConvSteps = 16;
  localparam int unsigned ConvW     = 4;
  localparam int unsigned BcdDigits = 5;

  // Bus bytes
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] LINE2_OFS    = 8'h40;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;

  // Micro-operations
  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_ADDR  = 3'd1,
    OP_CHAR  = 3'd2,
    OP_SIGN  = 3'd3,
    OP_CONV  = 3'd4,
    OP_DIGIT = 3'd5
  } uc_op_e;

  // Sequencing of the step counter
  typedef enum logic [1:0] {
    J_NEXT     = 2'd0,
    J_STAY     = 2'd1,
    J_CONV     = 2'd2,
    J_DISPATCH = 2'd3
  } uc_jmp_e;

  typedef struct packed {
    uc_op_e  op;
    uc_jmp_e jmp;
  } uc_word_t;

  localparam int unsigned PcW = 3;
  typedef logic [PcW-1:0] pc_t;

  localparam pc_t PC_LOAD  = 3'd0;
  localparam pc_t PC_ADDR  = 3'd1;
  localparam pc_t PC_CHAR  = 3'd2;
  localparam pc_t PC_SIGN  = 3'd3;
  localparam pc_t PC_CONV  = 3'd4;
  localparam pc_t PC_DIGIT = 3'd5;

  // Sequencer to datapath
  typedef struct packed {
    uc_op_e op;
    logic   fire;
    logic   emit;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic [2:0] action;
    logic       conv_done;
    logic       last;
  } stat_t;

  // Control store: one word per step
  function automatic uc_word_t uc_rom(input pc_t pc);
    uc_word_t w;
    case (pc)
      PC_LOAD:  w = '{op: OP_LOAD,  jmp: J_NEXT};
      PC_ADDR:  w = '{op: OP_ADDR,  jmp: J_DISPATCH};
      PC_CHAR:  w = '{op: OP_CHAR,  jmp: J_NEXT};
      PC_SIGN:  w = '{op: OP_SIGN,  jmp: J_NEXT};
      PC_CONV:  w = '{op: OP_CONV,  jmp: J_CONV};
      PC_DIGIT: w = '{op: OP_DIGIT, jmp: J_STAY};
      default:  w = '{op: OP_LOAD,  jmp: J_NEXT};
    endcase
    return w;
  endfunction

  // Branch table for the dispatch after the address command
  function automatic pc_t uc_dispatch(input logic [2:0] action);
    pc_t t;
    case (action)
      ACT_CHAR: t = PC_CHAR;
      ACT_SDEC: t = PC_SIGN;
      ACT_UDEC: t = PC_CONV;
      ACT_HEX:  t = PC_DIGIT;
      ACT_BIN:  t = PC_DIGIT;
      default:  t = PC_LOAD;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== src/lcdnw_seq.sv =====
// ----------------------------------------------------------------------------
// lcdnw_seq
// Step counter and control store: fetches one control word per step and
// works out the next step from the jump field and datapath status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "char_lcd_number_writer_core_macros.svh"

module lcdnw_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            slot_free_i,
  input  lcdnw_pkg::stat_t stat_i,
  output lcdnw_pkg::ctrl_t ctrl_o
);
  import lcdnw_pkg::*;

  pc_t      pc_q, pc_d;
  uc_word_t word;
  logic     emits;
  logic     fire;

  // Decode the current control word
  always_comb begin
    word  = uc_rom(pc_q);
    emits = (word.op == OP_ADDR) || (word.op == OP_CHAR) ||
            (word.op == OP_SIGN) || (word.op == OP_DIGIT);
    if (word.op == OP_LOAD) begin
      fire = in_valid_i;
    end else if (emits) begin
      fire = slot_free_i;
    end else begin
      fire = 1'b1;
    end
  end

  assign in_ready_o  = (word.op == OP_LOAD);
  assign ctrl_o.op   = word.op;
  assign ctrl_o.fire = fire;
  assign ctrl_o.emit = fire && emits;

  // Next step: hold when stalled, back to load after the last write
  always_comb begin
    pc_d = pc_q;
    if (fire) begin
      if (emits && stat_i.last) begin
        pc_d = PC_LOAD;
      end else begin
        case (word.jmp)
          J_NEXT:     pc_d = pc_q + pc_t'(1);
          J_STAY:     pc_d = pc_q;
          J_CONV:     pc_d = stat_i.conv_done ? pc_q + pc_t'(1) : pc_q;
          J_DISPATCH: pc_d = uc_dispatch(stat_i.action);
          default:    pc_d = PC_LOAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

  `LCDNW_ASSERT_NOW(a_pc_range, 1'b1, pc_q <= PC_DIGIT, "step counter out of program")
  `LCDNW_ASSERT_NEXT(a_last_to_load, ctrl_o.emit && stat_i.last, pc_q == PC_LOAD,
                     "last write did not return to load step")
  `LCDNW_ASSERT_NEXT(a_accept_leaves, in_valid_i && in_ready_o, !in_ready_o,
                     "new item taken while previous one in progress")

endmodule

`default_nettype wire

// ===== src/lcdnw_dpath.sv =====
// ----------------------------------------------------------------------------
// lcdnw_dpath
// Request registers, serial binary-to-BCD converter and bus byte selection
// for the LCD number writer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "char_lcd_number_writer_core_macros.svh"

module lcdnw_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lcdnw_pkg::ctrl_t ctrl_i,
  input  logic [2:0]       action_i,
  input  logic [1:0]       row_i,
  input  logic [5:0]       col_i,
  input  logic [15:0]      value_i,
  input  logic [4:0]       digit_count_i,
  input  logic [7:0]       char_code_i,
  output lcdnw_pkg::stat_t stat_o,
  output logic             is_data_o,
  output logic [7:0]       bus_byte_o
);
  import lcdnw_pkg::*;

  logic [2:0]             action_q;
  logic [7:0]             addr_q, addr_d;
  logic [7:0]             char_q;
  logic                   neg_q;
  logic [CntW-1:0]        n_q, n_d;
  logic [15:0]            sh_q, sh_d;
  logic [4*BcdDigits-1:0] bcd_q, bcd_d, bcd_adj;
  logic [ConvW-1:0]       cnt_q, cnt_d;
  logic                   load;
  logic                   is_neg;
  logic [7:0]             col_m1;
  logic [PosW-1:0]        pos;
  logic [3:0]             digit;
  logic [7:0]             digit_char;
  logic                   addr_last;
  logic                   last_flag;

  assign load   = ctrl_i.fire && (ctrl_i.op == OP_LOAD);
  assign is_neg = (action_i == ACT_SDEC) && value_i[15];

  // Address command from line and one-based column
  always_comb begin
    col_m1 = {2'b00, col_i} - 8'd1;
    if (row_i == 2'd1) begin
      addr_d = CMD_SET_ADDR | col_m1;
    end else begin
      addr_d = CMD_SET_ADDR | (col_m1 + LINE2_OFS);
    end
  end

  // Add-three adjust of each BCD digit
  always_comb begin
    for (int k = 0; k < BcdDigits; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  // Next values of the working registers
  always_comb begin
    n_d   = n_q;
    sh_d  = sh_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (load) begin
      n_d   = (digit_count_i > CntW'(MaxDigits)) ? CntW'(MaxDigits) : digit_count_i;
      sh_d  = is_neg ? (~value_i + 16'd1) : value_i;
      bcd_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.fire && (ctrl_i.op == OP_CONV)) begin
      bcd_d = {bcd_adj[4*BcdDigits-2:0], sh_q[15]};
      sh_d  = {sh_q[14:0], 1'b0};
      cnt_d = cnt_q + ConvW'(1);
    end else if (ctrl_i.emit && (ctrl_i.op == OP_DIGIT)) begin
      n_d = n_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      action_q <= action_i;
      addr_q   <= addr_d;
      char_q   <= char_code_i;
      neg_q    <= is_neg;
    end
    n_q   <= n_d;
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
  end

  // Pick the digit at the current position, most significant first
  always_comb begin
    pos   = PosW'(n_q - CntW'(1));
    digit = 4'd0;
    case (action_q)
      ACT_UDEC, ACT_SDEC: begin
        if (pos < PosW'(BcdDigits)) begin
          digit = bcd_q[{pos[2:0], 2'b00} +: 4];
        end
      end
      ACT_HEX: begin
        if (pos < PosW'(4)) begin
          digit = sh_q[{pos[1:0], 2'b00} +: 4];
        end
      end
      ACT_BIN: digit = {3'b000, sh_q[pos]};
      default: digit = 4'd0;
    endcase
    if (digit < 4'd10) begin
      digit_char = CH_ZERO + {4'b0000, digit};
    end else begin
      digit_char = CH_UPPER_A + {4'b0000, digit} - 8'd10;
    end
  end

  // Address command is last when nothing follows it
  assign addr_last = (action_q > ACT_BIN) ||
                     (((action_q == ACT_UDEC) || (action_q == ACT_HEX) ||
                       (action_q == ACT_BIN)) && (n_q == '0));

  // Bus byte, register select and last flag per step
  always_comb begin
    is_data_o  = 1'b1;
    bus_byte_o = digit_char;
    last_flag  = 1'b0;
    case (ctrl_i.op)
      OP_ADDR: begin
        is_data_o  = 1'b0;
        bus_byte_o = addr_q;
        last_flag  = addr_last;
      end
      OP_CHAR: begin
        bus_byte_o = char_q;
        last_flag  = 1'b1;
      end
      OP_SIGN: begin
        bus_byte_o = neg_q ? CH_MINUS : CH_PLUS;
        last_flag  = (n_q == '0);
      end
      OP_DIGIT: begin
        last_flag = (n_q == CntW'(1));
      end
      default: last_flag = 1'b0;
    endcase
  end

  assign stat_o.last      = last_flag;
  assign stat_o.action    = action_q;
  assign stat_o.conv_done = (cnt_q == ConvW'(ConvSteps - 1));

  `LCDNW_ASSERT_NOW(a_digit_nonzero, ctrl_i.emit && (ctrl_i.op == OP_DIGIT), n_q != '0,
                    "digit written with no digits left")
  `LCDNW_ASSERT_NOW(a_conv_decimal, ctrl_i.fire && (ctrl_i.op == OP_CONV),
                    (action_q == ACT_UDEC) || (action_q == ACT_SDEC),
                    "conversion step outside decimal mode")

endmodule

`default_nettype wire

// ===== src/char_lcd_number_writer_core.sv =====
// First bus write: the address command, emitted by the address step after the
// load step takes the item. Writes: a character after the address command;
// hex and binary digits after it; decimal digits after the sign (signed only)
// and the 16-step bit-serial BCD converter, one bus write per step, each held
// while the output register is full; a zero digit count skips the converter.
// Reset: asynchronous, active low; clears the step counter and output valid.
// ----------------------------------------------------------------------------
// char_lcd_number_writer_core
// Turns one display request into the character-LCD bus writes: address
// command, then a character, or the digits of a number (sign first if signed).
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_number_writer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [1:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic [15:0] value_i,
  input  logic [4:0]  digit_count_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_data_o,
  output logic [7:0]  bus_byte_o,
  output logic        last_write_o
);
  import lcdnw_pkg::*;

  ctrl_t      ctrl;
  stat_t      stat;
  logic       slot_free;
  logic       emit_is_data;
  logic [7:0] emit_byte;
  logic       out_valid_q;
  logic       is_data_q;
  logic [7:0] bus_byte_q;
  logic       last_q;

  assign slot_free = !out_valid_q || out_ready_i;

  lcdnw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .slot_free_i (slot_free),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  lcdnw_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .action_i      (action_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .char_code_i   (char_code_i),
    .stat_o        (stat),
    .is_data_o     (emit_is_data),
    .bus_byte_o    (emit_byte)
  );

  // Output register: load a new write, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      is_data_q  <= emit_is_data;
      bus_byte_q <= emit_byte;
      last_q     <= stat.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_data_o    = is_data_q;
  assign bus_byte_o   = bus_byte_q;
  assign last_write_o = last_q;

endmodule

`default_nettype wire
